[sv/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and helpers of the phase to complex transmission
// block: fixed-point formats, reduction constants and the arctangent table.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // field widths
   localparam int unsigned SAMPLE_W    = 24;
   localparam int unsigned OUT_W       = 24;
   localparam int unsigned SCALE_W     = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned PROD_W      = SAMPLE_W + SCALE_W;
   localparam int unsigned ANGLE_W     = 32;
   localparam int unsigned TABLE_LEN   = 30;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_SCALE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WEAK_MODE   = CSR_INDEX_W'(1);

   // register reset values
   localparam logic [SCALE_W-1:0] PHASE_SCALE_RESET = 32'h0100_0000;

   // 2*pi in Q36 and its reciprocal in Q26
   localparam logic [38:0] TWO_PI_Q36 = 39'd431777206545;
   localparam logic [23:0] RECIP_Q62  =
      24'(64'h4000_0000_0000_0000 / {25'd0, TWO_PI_Q36});
   localparam logic [18:0] TWO_PI_HI  = TWO_PI_Q36[38:20];
   localparam logic [19:0] TWO_PI_LO  = TWO_PI_Q36[19:0];

   // fold thresholds in Q30
   localparam logic [32:0] HALF_PI_Q30     = 33'd1686629713;
   localparam logic [32:0] PI_Q30          = 33'd3373259426;
   localparam logic [32:0] THREE_HALF_PI_Q30 = PI_Q30 + HALF_PI_Q30;
   localparam logic [32:0] TWO_PI_Q30      = 33'd6746518852;

   // cordic start gain and unit output
   localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [OUT_W-1:0]   ONE_Q16         = 24'sd65536;

   // round(atan(2^-i) * 2^30)
   localparam logic [ANGLE_W-1:0] ARCTAN_Q30 [TABLE_LEN] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
      32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
      32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
      32'd32,        32'd16,        32'd8,         32'd4,         32'd2
   };

   // state carried from cell to cell
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      neg;
      logic signed [OUT_W-1:0]   weak_im;
      logic signed [ANGLE_W-1:0] x;
      logic signed [ANGLE_W-1:0] y;
      logic signed [ANGLE_W-1:0] z;
   } cell_type;

   // one finished result
   typedef struct packed {
      logic signed [OUT_W-1:0] real_part;
      logic signed [OUT_W-1:0] imag_part;
      logic                    last_out;
   } result_type;

   // clamp to the signed 24 bit output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 56'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -56'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/ptc_if.sv]
// ----------------------------------------------------------------------------
// ptc_if
// Valid/ready channels of the block: pixel requests, transmission
// responses and register writes.
// ----------------------------------------------------------------------------

// pixel request channel
interface ptc_req_if;
   import ptc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] potential_sample;
   logic                       last_sample;

   modport source (output valid, output potential_sample, output last_sample, input ready);
   modport sink   (input valid, input potential_sample, input last_sample, output ready);
endinterface

// transmission response channel
interface ptc_rsp_if;
   import ptc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] real_part;
   logic signed [OUT_W-1:0] imag_part;
   logic                    last_out;

   modport source (output valid, output real_part, output imag_part, output last_out,
                   input ready);
   modport sink   (input valid, input real_part, input imag_part, input last_out,
                   output ready);
endinterface

// register write channel
interface ptc_csr_if;
   import ptc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/ptc_phase_reduce.sv]
// ----------------------------------------------------------------------------
// ptc_phase_reduce
// Forms the phase product, reduces it modulo 2*pi by reciprocal multiply
// with correction, folds it into [-pi/2, pi/2] and prepares the weak-phase
// value. Six register stages, all held while advance is low.
// ----------------------------------------------------------------------------
module ptc_phase_reduce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            accept,
   input  logic signed [ptc_pkg::SAMPLE_W-1:0] sample,
   input  logic                            last,
   input  logic [ptc_pkg::SCALE_W-1:0]     phase_scale,
   output ptc_pkg::cell_type               head
);
   import ptc_pkg::*;

   logic [5:0] valid_ff;
   logic [4:0] last_ff;

   logic signed [PROD_W:0]   prod_full;
   logic signed [PROD_W-1:0] p1_ff, p1_in;
   logic signed [PROD_W-1:0] p2_ff, p3_ff;
   logic signed [25:0]       p_hi;
   logic signed [50:0]       q_prod;
   logic signed [18:0]       q2_ff, q2_in;
   logic signed [PROD_W-1:0] w_sum;
   logic signed [PROD_W-1:0] w_shift;
   logic signed [OUT_W-1:0]  weak2_ff, weak2_in, weak3_ff, weak4_ff, weak5_ff;
   logic signed [38:0]       mh3_ff, mh3_in;
   logic signed [39:0]       ml3_ff, ml3_in;
   logic signed [59:0]       r_full;
   logic signed [40:0]       r4_ff, r4_in;
   logic signed [40:0]       m_val;
   logic [32:0]              a5_ff, a5_in;
   logic signed [33:0]       z_wide;
   logic                     neg6;
   cell_type                 head_ff, head_in;

   // stage 1: phase product, signed Q20.36
   always_comb begin
      prod_full = sample * $signed({1'b0, phase_scale});
      p1_in     = prod_full[PROD_W-1:0];
   end

   // stage 2: quotient estimate and weak-phase rounding
   always_comb begin
      p_hi     = p1_ff[PROD_W-1:30];
      q_prod   = p_hi * $signed({1'b0, RECIP_Q62});
      q2_in    = q_prod[50:32];
      w_sum    = p1_ff + 56'sd524288;
      w_shift  = w_sum >>> 20;
      weak2_in = sat_out(w_shift);
   end

   // stage 3: quotient times 2*pi in two partial products
   always_comb begin
      mh3_in = q2_ff * $signed({1'b0, TWO_PI_HI});
      ml3_in = q2_ff * $signed({1'b0, TWO_PI_LO});
   end

   // stage 4: remainder, within one period of the target range
   always_comb begin
      r_full = p3_ff - (mh3_ff <<< 20) - ml3_ff;
      r4_in  = r_full[40:0];
   end

   // stage 5: correct remainder into [0, 2*pi), drop to Q30
   always_comb begin
      if (r4_ff[40]) begin
         m_val = r4_ff + $signed({2'b00, TWO_PI_Q36});
      end else if (r4_ff >= $signed({2'b00, TWO_PI_Q36})) begin
         m_val = r4_ff - $signed({2'b00, TWO_PI_Q36});
      end else begin
         m_val = r4_ff;
      end
      a5_in = m_val[38:6];
   end

   // stage 6: fold into [-pi/2, pi/2]
   always_comb begin
      if (a5_ff < HALF_PI_Q30) begin
         z_wide = $signed({1'b0, a5_ff});
         neg6   = 1'b0;
      end else if (a5_ff < THREE_HALF_PI_Q30) begin
         z_wide = $signed({1'b0, a5_ff}) - $signed({1'b0, PI_Q30});
         neg6   = 1'b1;
      end else begin
         z_wide = $signed({1'b0, a5_ff}) - $signed({1'b0, TWO_PI_Q30});
         neg6   = 1'b0;
      end
      head_in.valid   = valid_ff[4];
      head_in.last    = last_ff[4];
      head_in.neg     = neg6;
      head_in.weak_im = weak5_ff;
      head_in.x       = CORDIC_GAIN_Q30;
      head_in.y       = '0;
      head_in.z       = z_wide[ANGLE_W-1:0];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], accept};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff  <= {last_ff[3:0], last};
         p1_ff    <= p1_in;
         p2_ff    <= p1_ff;
         q2_ff    <= q2_in;
         weak2_ff <= weak2_in;
         p3_ff    <= p2_ff;
         mh3_ff   <= mh3_in;
         ml3_ff   <= ml3_in;
         weak3_ff <= weak2_ff;
         r4_ff    <= r4_in;
         weak4_ff <= weak3_ff;
         a5_ff    <= a5_in;
         weak5_ff <= weak4_ff;
         head_ff  <= head_in;
      end
   end

   always_comb begin
      head       = head_ff;
      head.valid = valid_ff[5];
   end

endmodule

[sv/ptc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ptc_cordic_cell
// One CORDIC rotation step with a fixed shift, registered toward the next
// cell of the chain.
// ----------------------------------------------------------------------------
module ptc_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ptc_pkg::cell_type cell_i,
   output ptc_pkg::cell_type cell_o
);
   import ptc_pkg::*;

   logic signed [ANGLE_W-1:0] dx;
   logic signed [ANGLE_W-1:0] dy;
   cell_type                  cell_ff, cell_in;

   // rotate toward zero residual angle
   always_comb begin
      dx      = $signed(cell_i.y) >>> STAGE;
      dy      = $signed(cell_i.x) >>> STAGE;
      cell_in = cell_i;
      if (!cell_i.z[ANGLE_W-1]) begin
         cell_in.x = cell_i.x - dx;
         cell_in.y = cell_i.y + dy;
         cell_in.z = cell_i.z - $signed(ARCTAN_Q30[STAGE]);
      end else begin
         cell_in.x = cell_i.x + dx;
         cell_in.y = cell_i.y - dy;
         cell_in.z = cell_i.z + $signed(ARCTAN_Q30[STAGE]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

[sv/ptc_out_stage.sv]
// ----------------------------------------------------------------------------
// ptc_out_stage
// Sign restore, rounding to Q8.16 and mode select, followed by an output
// register with a skid entry that decouples the pipeline from the sink.
// ----------------------------------------------------------------------------
module ptc_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  ptc_pkg::cell_type tail,
   input  logic              weak_mode,
   output logic              advance,
   ptc_rsp_if.source         rsp_if
);
   import ptc_pkg::*;

   logic signed [ANGLE_W:0]  c_sgn, s_sgn;
   logic signed [ANGLE_W:0]  c_rnd, s_rnd;
   result_type               fmt;
   result_type               main_ff, main_in, skid_ff, skid_in;
   logic                     main_valid_ff, main_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic                     take;

   // restore sign of folded angle and round half up
   always_comb begin
      c_sgn = tail.neg ? -$signed({tail.x[ANGLE_W-1], tail.x})
                       :  $signed({tail.x[ANGLE_W-1], tail.x});
      s_sgn = tail.neg ? -$signed({tail.y[ANGLE_W-1], tail.y})
                       :  $signed({tail.y[ANGLE_W-1], tail.y});
      c_rnd = (c_sgn + 33'sd8192) >>> 14;
      s_rnd = (s_sgn + 33'sd8192) >>> 14;
      if (weak_mode) begin
         fmt.real_part = ONE_Q16;
         fmt.imag_part = tail.weak_im;
      end else begin
         fmt.real_part = sat_out(PROD_W'(c_rnd));
         fmt.imag_part = sat_out(PROD_W'(s_rnd));
      end
      fmt.last_out = tail.last;
   end

   // output register and skid entry
   always_comb begin
      advance       = !skid_valid_ff;
      take          = main_valid_ff && rsp_if.ready;
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (advance) begin
         if (tail.valid) begin
            if (!main_valid_ff || take) begin
               main_in       = fmt;
               main_valid_in = 1'b1;
            end else begin
               skid_in       = fmt;
               skid_valid_in = 1'b1;
            end
         end else if (take) begin
            main_valid_in = 1'b0;
         end
      end else if (take) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid     = main_valid_ff;
   assign rsp_if.real_part = main_ff.real_part;
   assign rsp_if.imag_part = main_ff.imag_part;
   assign rsp_if.last_out  = main_ff.last_out;

   // skid entry only fills behind a waiting output
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a result while output register is empty");

   // a stalled skid entry is not dropped
   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_if.ready) |=> skid_valid_ff)
      else $error("skid entry lost while the sink stalls");

   // a result held at the chain end survives the stall
   a_tail_kept: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !advance) |=> tail.valid)
      else $error("result at end of chain dropped during stall");

endmodule

[sv/phase_to_complex_transmission.sv]
// ----------------------------------------------------------------------------
// phase_to_complex_transmission
// Path from request to response: six phase reduction stages, one register per
// CORDIC cell, one output register.
// Throughput: one request per cycle while the skid entry is empty, set by the fully pipelined cell chain.
// A skid entry keeps requests flowing after the sink stalls, until the skid entry is full.
// Synchronous reset clears all valids, sets phase_scale to 1.0 and full mode.
// ----------------------------------------------------------------------------
module phase_to_complex_transmission #(
   parameter int unsigned CORDIC_STAGES = 18
) (
   input  logic      clock,
   input  logic      reset,
   ptc_req_if.sink   req_if,
   ptc_rsp_if.source rsp_if,
   ptc_csr_if.sink   csr_if
);
   import ptc_pkg::*;

   localparam int unsigned NCELL = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   logic [SCALE_W-1:0] phase_scale_ff;
   logic               weak_mode_ff;
   logic               advance;
   logic               accept;
   cell_type           chain [NCELL+1];

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_scale_ff <= PHASE_SCALE_RESET;
         weak_mode_ff   <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_PHASE_SCALE: phase_scale_ff <= csr_if.wdata;
            CSR_WEAK_MODE:   weak_mode_ff   <= csr_if.wdata[0];
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;

   // phase product and range reduction
   ptc_phase_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .accept      (accept),
      .sample      (req_if.potential_sample),
      .last        (req_if.last_sample),
      .phase_scale (phase_scale_ff),
      .head        (chain[0])
   );

   // cordic rotation chain
   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      ptc_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_i  (chain[g]),
         .cell_o  (chain[g+1])
      );
   end

   // rounding, mode select and response buffering
   ptc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .tail      (chain[NCELL]),
      .weak_mode (weak_mode_ff),
      .advance   (advance),
      .rsp_if    (rsp_if)
   );

endmodule

[test/phase_to_complex_transmission_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_to_complex_transmission_tb
// Streams potential samples through the block under both transmission modes
// and a range of phase scales, with random idling on both channels and
// one long response stall. Each response is compared against a fixed-point
// cos/sin and weak-phase prediction computed in the bench.
// ----------------------------------------------------------------------------
module phase_to_complex_transmission_tb;
   import ptc_pkg::*;

   localparam int unsigned STAGES         = 18;
   localparam int unsigned PIPE_LATENCY   = STAGES + 7;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES  = 12;
   localparam int unsigned PHASE_PIXELS   = 52;
   localparam int unsigned LONG_HOLD      = 300;

   // phase constants in the predictor's own formats
   localparam longint TWO_PI_Q36_C    = 64'sd431777206545;
   localparam longint HALF_PI_Q30_C   = 64'sd1686629713;
   localparam longint PI_Q30_C        = 64'sd3373259426;
   localparam longint TWO_PI_Q30_C    = 64'sd6746518852;
   localparam longint GAIN_Q30_C      = 64'sd652032874;
   localparam longint UNIT_Q16_C      = 64'sd65536;
   localparam longint HALF_LSB_Q20    = 64'sd524288;
   localparam longint HALF_LSB_Q14    = 64'sd8192;
   localparam int     ANGLE_STEPS     = 30;

   // rotation angles atan(2^-i) in Q30
   localparam longint ATAN_STEP_Q30 [ANGLE_STEPS] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516,  16775851,  8388437,   4194283,   2097149,
      1048576,   524288,    262144,    131072,    65536,
      32768,     16384,     8192,      4096,      2048,
      1024,      512,       256,       128,       64,
      32,        16,        8,         4,         2
   };

   // expected transmissions, register copies and the mismatch count
   class expected_transmissions;
      logic [SCALE_W-1:0] scale;
      bit                 weak_mode;
      result_type         pending_q[$];
      int                 errors;

      function new();
         scale     = PHASE_SCALE_RESET;
         weak_mode = 1'b0;
         errors    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_PHASE_SCALE) begin
            scale = data[SCALE_W-1:0];
         end else if (index == CSR_WEAK_MODE) begin
            weak_mode = data[0];
         end
      endfunction

      function logic signed [OUT_W-1:0] clamp_out(longint v);
         logic signed [OUT_W-1:0] r;
         if (v > 64'sd8388607) begin
            r = 24'sh7FFFFF;
         end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
         end else begin
            r = v[OUT_W-1:0];
         end
         return r;
      endfunction

      // phase product, then cos/sin by rotation or the weak-phase pair
      function result_type transmission_of(logic signed [SAMPLE_W-1:0] potential,
                                           logic last);
         longint     prod;
         longint     m;
         longint     z;
         longint     x;
         longint     y;
         longint     dx;
         longint     dy;
         bit         neg;
         result_type r;
         prod       = longint'(potential) * longint'({32'b0, scale});
         r.last_out = last;
         if (weak_mode) begin
            r.real_part = UNIT_Q16_C[OUT_W-1:0];
            r.imag_part = clamp_out((prod + HALF_LSB_Q20) >>> 20);
         end else begin
            m = prod % TWO_PI_Q36_C;
            if (m < 0) begin
               m += TWO_PI_Q36_C;
            end
            m   = m >>> 6;
            neg = 1'b0;
            // fold into [-pi/2, pi/2]
            if (m < HALF_PI_Q30_C) begin
               z = m;
            end else if (m < PI_Q30_C + HALF_PI_Q30_C) begin
               z   = m - PI_Q30_C;
               neg = 1'b1;
            end else begin
               z = m - TWO_PI_Q30_C;
            end
            x = GAIN_Q30_C;
            y = 0;
            for (int i = 0; i < STAGES && i < ANGLE_STEPS; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (z >= 0) begin
                  x -= dx;
                  y += dy;
                  z -= ATAN_STEP_Q30[i];
               end else begin
                  x += dx;
                  y -= dy;
                  z += ATAN_STEP_Q30[i];
               end
            end
            if (neg) begin
               x = -x;
               y = -y;
            end
            r.real_part = clamp_out((x + HALF_LSB_Q14) >>> 14);
            r.imag_part = clamp_out((y + HALF_LSB_Q14) >>> 14);
         end
         return r;
      endfunction

      function void note_pixel(logic signed [SAMPLE_W-1:0] potential, logic last);
         pending_q.push_back(transmission_of(potential, last));
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_transmission(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im,
                              logic last);
         result_type e;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response re=%0d im=%0d last=%0b",
                                      re, im, last));
         end else begin
            e = pending_q.pop_front();
            if (re !== e.real_part || im !== e.imag_part || last !== e.last_out) begin
               report_mismatch($sformatf("re %0d/%0d im %0d/%0d last %0b/%0b (got/exp)",
                                         re, e.real_part, im, e.imag_part,
                                         last, e.last_out));
            end
         end
      endtask

      task check_drained();
         while (pending_q.size() != 0) begin
            void'(pending_q.pop_front());
            report_mismatch("response never arrived");
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ptc_req_if req_if ();
   ptc_rsp_if rsp_if ();
   ptc_csr_if csr_if ();

   expected_transmissions expect_q;

   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_hold_left;
   int hold_requests;
   int hold_served;
   int idle_cycles;

   phase_to_complex_transmission #(
      .CORDIC_STAGES(STAGES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response ready: long hold-off when asked, random idling otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served   = hold_requests;
         rsp_hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expect_q.note_pixel(req_if.potential_sample, req_if.last_sample);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            expect_q.check_transmission(rsp_if.real_part, rsp_if.imag_part,
                                        rsp_if.last_out);
         end
         if (csr_if.valid && csr_if.ready) begin
            expect_q.write_register(csr_if.index, csr_if.wdata);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one register write, valid dropped afterwards
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // one pixel request; valid stays up for a following request
   task automatic send_pixel(logic signed [SAMPLE_W-1:0] potential, logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.potential_sample <= potential;
      req_if.last_sample      <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // stop requesting and wait for every expected response
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expect_q.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_potential();
      logic signed [SAMPLE_W-1:0] r;
      case ($urandom_range(0, 3))
         0: r = SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
         1: begin
            case ($urandom_range(0, 3))
               0: r = 24'sh7FFFFF;
               1: r = 24'sh800000;
               2: r = 24'sh000000;
               default: r = 24'shFFFFFF;
            endcase
         end
         default: r = SAMPLE_W'($urandom);
      endcase
      return r;
   endfunction

   // directed samples: extremes, one radian and the fold boundaries at unit scale
   logic signed [SAMPLE_W-1:0] directed_potentials [12] = '{
      24'sd0, 24'sd1, -24'sd1, 24'sh7FFFFF, 24'sh800000, 24'sd4096,
      24'sd6433, 24'sd6434, 24'sd12868, 24'sd19302, 24'sd25736, -24'sd6434
   };

   // stimulus
   initial begin
      logic [SCALE_W-1:0] scale;
      bit                 weak_sel;
      expect_q                 = new();
      req_idle_pct             = 11;
      rsp_idle_pct             = 70;
      hold_requests            = 0;
      reset                   <= 1'b1;
      req_if.valid            <= 1'b0;
      req_if.potential_sample <= '0;
      req_if.last_sample      <= 1'b0;
      csr_if.valid            <= 1'b0;
      csr_if.index            <= '0;
      csr_if.wdata            <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests in full mode at the reset scale, then in weak mode
      foreach (directed_potentials[i]) begin
         send_pixel(directed_potentials[i], i[0]);
      end
      drain_responses();
      write_csr(CSR_WEAK_MODE, 32'hFFFF_FFFF);
      foreach (directed_potentials[i]) begin
         send_pixel(directed_potentials[i], ~i[0]);
      end
      drain_responses();

      // random phases over scale and mode settings
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         case (k % 6)
            0: scale = 32'hFFFF_FFFF;
            1: scale = 32'h0000_0000;
            2: scale = $urandom;
            3: scale = 32'h0000_0001;
            4: scale = PHASE_SCALE_RESET;
            default: scale = $urandom_range(0, 32'h0400_0000);
         endcase
         weak_sel = (k >= 6);
         write_csr(CSR_PHASE_SCALE, scale);
         write_csr(CSR_WEAK_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), weak_sel});
         // writes to unused indexes must be ignored
         write_csr((k == 0) ? CSR_INDEX_W'(8'hFF) : CSR_INDEX_W'($urandom_range(2, 255)),
                   $urandom);
         if (k < 4) begin
            req_idle_pct = 11;
            rsp_idle_pct = 70;
         end else if (k < 8) begin
            req_idle_pct = 70;
            rsp_idle_pct = 11;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // long response stall while requests keep coming
         if (k == 10) begin
            hold_requests++;
         end
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            send_pixel(random_potential(), ($urandom_range(0, 15) == 0));
         end
         drain_responses();
      end

      repeat (PIPE_LATENCY + 8) @(posedge clock);
      expect_q.check_drained();
      if (expect_q.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
